### sv/ptsr_pkg.sv
// shared types and constants of the pausable timestamp rescaler
`default_nettype none

package ptsr_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_PAUSE   = 2'd0;
    localparam logic [1:0] CMD_RESUME  = 2'd1;
    localparam logic [1:0] CMD_CONVERT = 2'd2;

    // configuration register indexes
    localparam logic CFG_IDX_FREQ   = 1'b0;
    localparam logic CFG_IDX_ORIGIN = 1'b1;

    localparam int TS_W     = 63;
    localparam int TB_W     = 32;
    localparam int FREQ_W   = 32;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 128;

    localparam logic [TS_W-1:0] MAX63 = {TS_W{1'b1}};

    // divider retires two quotient bits a cycle over a 64-bit dividend
    localparam int DIV_W     = 64;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_RESUME,
        ST_DIFF,
        ST_DIV_WHOLE,
        ST_MUL_REM,
        ST_FRAC_LOAD,
        ST_DIV_FRAC,
        ST_MUL_LO,
        ST_ADD_LO,
        ST_MUL_HI,
        ST_ADD_HI,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [FREQ_W-1:0] rem;
        logic [DIV_W-1:0]  num;
    } div_t;

endpackage

`default_nettype wire

### sv/pausable_timestamp_rescaler.sv
// top level of the pausable timestamp rescaler
// throughput: one item at a time, the next item is taken once the result is registered;
//   the length of a full convert is set by two passes of the radix-4 divider
// reset: synchronous active-low aresetn clears the sequencer, the pause state, the output
//   valid and loads counter_frequency = 10000000, origin_time = 0
`default_nettype none

module pausable_timestamp_rescaler (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [ptsr_pkg::TS_W-1:0]        cfg_wdata,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // fields from bit 0 up: timestamp[62:0], time_base[94:63], zero pad [95]
    input  wire logic [ptsr_pkg::IN_DATA_W-1:0]   s_tdata,
    // fields from bit 0 up: cmd[1:0]
    input  wire logic [1:0]                       s_tuser,
    // result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // fields from bit 0 up: accepted[0], media_ticks[63:1], paused_total[126:64],
    // is_paused[127]
    output logic [ptsr_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import ptsr_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    // sequencer
    state_t state_reg, state_next;

    // configuration
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [TS_W-1:0]   origin_reg, origin_next;

    // pause bookkeeping
    logic              paused_reg, paused_next;
    logic [TS_W-1:0]   pause_start_reg, pause_start_next;
    logic [TS_W-1:0]   pause_sum_reg, pause_sum_next;

    // captured item
    logic [1:0]        cmd_reg, cmd_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [TB_W-1:0]   tb_reg, tb_next;

    // datapath of the convert sequence
    logic [TS_W-1:0]   eff_reg, eff_next;      // timestamp, clamped to pause start while paused
    logic [DIV_W-1:0]  sub_reg, sub_next;      // origin plus paused total
    logic [DIV_W-1:0]  num_reg, num_next;      // dividend / quotient shift register
    logic [FREQ_W-1:0] rem_reg, rem_next;      // partial remainder
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TS_W-1:0]   whole_reg, whole_next;  // whole seconds
    logic [DIV_W-1:0]  prod_reg, prod_next;
    logic [95:0]       acc_reg, acc_next;      // unsaturated media ticks
    logic              accept_reg, accept_next;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // shared units
    logic [FREQ_W-1:0] mul_a;
    logic [DIV_W-1:0]  mul_prod;
    div_t              div_one, div_two;

    logic              s_accept;
    logic              out_free;
    logic [DIV_W-1:0]  resume_sum;
    logic [DIV_W-1:0]  elapsed;
    logic              empty_conv;
    logic [TS_W-1:0]   media_sat;

    // one restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic div_t div_step(input div_t cur, input logic [FREQ_W-1:0] d);
        logic [FREQ_W:0] r;
        logic            q;
        div_t            res;
        r = {cur.rem, cur.num[DIV_W-1]};
        q = (r >= {1'b0, d});
        if (q) begin
            r = r - {1'b0, d};
        end
        res.rem = r[FREQ_W-1:0];
        res.num = {cur.num[DIV_W-2:0], q};
        return res;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // two chained steps give the radix-4 divider
    assign div_one = div_step('{rem: rem_reg, num: num_reg}, freq_reg);
    assign div_two = div_step(div_one, freq_reg);

    // shared 32x32 multiplier, second operand is always the time base
    always_comb begin
        case (state_reg)
            ST_MUL_LO: mul_a = whole_reg[31:0];
            ST_MUL_HI: mul_a = {1'b0, whole_reg[TS_W-1:32]};
            default:   mul_a = rem_reg;
        endcase
    end
    assign mul_prod = {32'b0, mul_a} * {32'b0, tb_reg};

    assign resume_sum = {1'b0, pause_sum_reg} + num_reg;
    assign elapsed    = {1'b0, eff_reg} - sub_reg;
    assign empty_conv = ({1'b0, eff_reg} <= sub_reg) || (tb_reg == '0) || (freq_reg == '0);
    assign media_sat  = (acc_reg[95:TS_W] != '0) ? MAX63 : acc_reg[TS_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                case (cmd_reg)
                    CMD_RESUME: begin
                        if (paused_reg && ts_reg >= pause_start_reg) begin
                            state_next = ST_RESUME;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    CMD_CONVERT: state_next = ST_DIFF;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_RESUME:    state_next = ST_DONE;
            ST_DIFF:      state_next = empty_conv ? ST_DONE : ST_DIV_WHOLE;
            ST_DIV_WHOLE: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_MUL_REM;
                end
            end
            ST_MUL_REM:   state_next = ST_FRAC_LOAD;
            ST_FRAC_LOAD: state_next = ST_DIV_FRAC;
            ST_DIV_FRAC: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:    state_next = ST_ADD_LO;
            ST_ADD_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_ADD_HI;
            ST_ADD_HI:    state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        freq_next        = freq_reg;
        origin_next      = origin_reg;
        paused_next      = paused_reg;
        pause_start_next = pause_start_reg;
        pause_sum_next   = pause_sum_reg;
        cmd_next         = cmd_reg;
        ts_next          = ts_reg;
        tb_next          = tb_reg;
        eff_next         = eff_reg;
        sub_next         = sub_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        whole_next       = whole_reg;
        prod_next        = prod_reg;
        acc_next         = acc_reg;
        accept_next      = accept_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;

        // register writes must only come while idle; the block itself does not enforce this
        if (cfg_we) begin
            case (cfg_index)
                CFG_IDX_FREQ:   freq_next   = cfg_wdata[FREQ_W-1:0];
                CFG_IDX_ORIGIN: origin_next = cfg_wdata;
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next = s_tuser;
                    ts_next  = s_tdata[TS_W-1:0];
                    tb_next  = s_tdata[TS_W+TB_W-1:TS_W];
                end
            end
            ST_PREP: begin
                acc_next    = '0;
                accept_next = 1'b0;
                case (cmd_reg)
                    CMD_PAUSE: begin
                        if (!paused_reg && ts_reg >= origin_reg) begin
                            pause_start_next = ts_reg;
                            paused_next      = 1'b1;
                            accept_next      = 1'b1;
                        end
                    end
                    CMD_RESUME: begin
                        // pause length, folded into the total next cycle in ST_RESUME
                        num_next = {1'b0, ts_reg - pause_start_reg};
                    end
                    CMD_CONVERT: begin
                        accept_next = 1'b1;
                        eff_next    = (paused_reg && ts_reg > pause_start_reg)
                                      ? pause_start_reg : ts_reg;
                        sub_next    = {1'b0, origin_reg} + {1'b0, pause_sum_reg};
                    end
                    default: ;
                endcase
            end
            ST_RESUME: begin
                // both terms below 2^63, so bit 63 flags saturation
                pause_sum_next   = resume_sum[DIV_W-1] ? MAX63 : resume_sum[TS_W-1:0];
                pause_start_next = '0;
                paused_next      = 1'b0;
                accept_next      = 1'b1;
            end
            ST_DIFF: begin
                num_next = elapsed;
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV_WHOLE, ST_DIV_FRAC: begin
                num_next = div_two.num;
                rem_next = div_two.rem;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_MUL_REM: begin
                whole_next = num_reg[TS_W-1:0];
                prod_next  = mul_prod;
            end
            ST_FRAC_LOAD: begin
                // rem * time_base + half the frequency, for round to nearest
                num_next = prod_reg + {33'b0, freq_reg[FREQ_W-1:1]};
                rem_next = '0;
                cnt_next = '0;
            end
            ST_MUL_LO: begin
                acc_next  = {64'b0, num_reg[31:0]};
                prod_next = mul_prod;
            end
            ST_ADD_LO: begin
                acc_next = acc_reg + {32'b0, prod_reg};
            end
            ST_MUL_HI: begin
                prod_next = mul_prod;
            end
            ST_ADD_HI: begin
                acc_next = acc_reg + {prod_reg, 32'b0};
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {paused_reg, pause_sum_reg, media_sat, accept_reg};
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            freq_reg        <= 32'd10000000;
            origin_reg      <= '0;
            paused_reg      <= 1'b0;
            pause_start_reg <= '0;
            pause_sum_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            freq_reg        <= freq_next;
            origin_reg      <= origin_next;
            paused_reg      <= paused_next;
            pause_start_reg <= pause_start_next;
            pause_sum_reg   <= pause_sum_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        ts_reg      <= ts_next;
        tb_reg      <= tb_next;
        eff_reg     <= eff_next;
        sub_reg     <= sub_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        whole_reg   <= whole_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        accept_reg  <= accept_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

### sv/ptsr_checker.sv
// port-level checker of the pausable timestamp rescaler and its bind
`default_nettype none

module ptsr_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ptsr_pkg::OUT_DATA_W-1:0] m_tdata
);
    import ptsr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // one item at a time: busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accepting an item");

    // a refused or unused command never carries media ticks
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[TS_W:1] == '0)
        else $error("media ticks on a refused item");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind pausable_timestamp_rescaler ptsr_checker u_ptsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
